// ----- rtl/swmm_pkg.sv -----
`timescale 1ns / 1ps

package swmm_pkg;

    // Widths fixed by the transaction fields and the configuration register.
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned WLEN_W   = 11;

    // Register index within the configuration space (taken from paddr[2]).
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    start_req;
    } item_t;

    typedef struct packed {
        sample_t window_min;
        sample_t window_max;
    } result_t;

    // Command from the top level to one deque engine.
    typedef struct packed {
        logic    go;
        logic    clr;
        logic    start;
        sample_t sample;
    } dq_cmd_t;

    typedef enum logic [1:0] {
        DQ_IDLE,
        DQ_DROP,
        DQ_POP
    } dq_state_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } top_state_t;

endpackage

// ----- rtl/swmm_deque.sv -----
`timescale 1ns / 1ps

module swmm_deque #(
    parameter int unsigned MAX_WINDOW = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swmm_pkg::dq_cmd_t                     cmd,
    input  logic [$clog2(2*MAX_WINDOW)-1:0]       pos,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]       win,
    output logic                                  idle,
    output swmm_pkg::sample_t                     head_value
);
    import swmm_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WINDOW);
    localparam int unsigned OW = $clog2(MAX_WINDOW + 1);
    localparam int unsigned PW = $clog2(2 * MAX_WINDOW);

    // Ring store of the deque entries; the head entry is also cached in registers.
    sample_t           mem_val [MAX_WINDOW];
    logic [PW-1:0]     mem_pos [MAX_WINDOW];

    dq_state_t         state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [OW-1:0]     occ_reg, occ_next;
    sample_t           hval_reg, hval_next;
    logic [PW-1:0]     hpos_reg, hpos_next;
    sample_t           smp_reg, smp_next;
    logic [PW-1:0]     spos_reg, spos_next;

    sample_t           rd_a_val;
    logic [PW-1:0]     rd_a_pos;
    sample_t           rd_b_val;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [PW-1:0]     age;
    logic              drop;
    logic [AW-1:0]     tail_head;
    logic [OW-1:0]     tail_occ;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [OW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(offset);
        if (sum >= (AW+1)'(MAX_WINDOW))
        begin
            sum = sum - (AW+1)'(MAX_WINDOW);
        end
        return sum[AW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DQ_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hval_reg <= hval_next;
        hpos_reg <= hpos_next;
        smp_reg  <= smp_next;
        spos_reg <= spos_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_val[waddr] <= smp_reg;
            mem_pos[waddr] <= spos_reg;
        end
        rd_a_val <= mem_val[raddr_a];
        rd_a_pos <= mem_pos[raddr_a];
        rd_b_val <= mem_val[raddr_b];
    end

    always_comb
    begin
        if (spos_reg >= hpos_reg)
        begin
            age = spos_reg - hpos_reg;
        end
        else
        begin
            age = spos_reg - hpos_reg + PW'(2 * MAX_WINDOW);
        end
        drop = (occ_reg != '0) && (age >= PW'(win));
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        occ_next   = occ_reg;
        hval_next  = hval_reg;
        hpos_next  = hpos_reg;
        smp_next   = smp_reg;
        spos_next  = spos_reg;
        we         = 1'b0;
        waddr      = head_reg;
        tail_head  = head_reg;
        tail_occ   = occ_reg;

        unique case (state_reg) inside
            DQ_IDLE:
            begin
                if (cmd.clr)
                begin
                    head_next = '0;
                    occ_next  = '0;
                end
                else if (cmd.go)
                begin
                    if (cmd.start)
                    begin
                        head_next = '0;
                        occ_next  = '0;
                    end
                    smp_next   = cmd.sample;
                    spos_next  = pos;
                    state_next = DQ_DROP;
                end
            end
            DQ_DROP, DQ_POP:
            begin
                // The expired head leaves first; its successor was read at head + 1.
                if (state_reg == DQ_DROP && drop)
                begin
                    tail_head = ring_add(head_reg, OW'(1));
                    tail_occ  = occ_reg - OW'(1);
                    hval_next = rd_a_val;
                    hpos_next = rd_a_pos;
                end
                head_next = tail_head;
                if (tail_occ != '0 && rd_b_val >= smp_reg)
                begin
                    occ_next   = tail_occ - OW'(1);
                    state_next = DQ_POP;
                end
                else
                begin
                    occ_next   = tail_occ;
                    state_next = DQ_IDLE;
                    if (tail_occ < OW'(MAX_WINDOW))
                    begin
                        we       = 1'b1;
                        waddr    = ring_add(tail_head, tail_occ);
                        occ_next = tail_occ + OW'(1);
                        if (tail_occ == '0)
                        begin
                            hval_next = smp_reg;
                            hpos_next = spos_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = DQ_IDLE;
            end
        endcase

        // Prefetch the entry behind the head and the current tail every cycle.
        raddr_a = ring_add(head_next, OW'(1));
        raddr_b = ring_add(head_next, occ_next - OW'(1));
    end

    assign idle       = (state_reg == DQ_IDLE);
    assign head_value = hval_reg;

endmodule

// ----- rtl/sliding_window_min_max.sv -----
`timescale 1ns / 1ps
// A result is registered once both deque engines have finished with its sample: each
// engine reads its memories, may drop the expired head, then pops one tail entry per
// cycle while the sample beats the tail. The next transaction is taken as the last
// finishes, if the output register can take the pending result.
// Reset clears both deques, the counters and the output valid flag; window_length is 1.

module sliding_window_min_max #(
    parameter int unsigned MAX_WINDOW = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  swmm_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output swmm_pkg::result_t result
);
    import swmm_pkg::*;

    localparam int unsigned OW = $clog2(MAX_WINDOW + 1);
    localparam int unsigned PW = $clog2(2 * MAX_WINDOW);

    // Configuration and sequence counters.
    logic [WLEN_W-1:0] wlen_reg, wlen_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [OW-1:0]     fill_reg, fill_next;
    top_state_t        st_reg, st_next;
    logic              emit_reg, emit_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [OW-1:0]     win_eff;
    logic              cfg_wr;
    logic              item_acc;
    logic              units_idle;
    logic              slot_free;
    logic              can_finish;
    logic [PW-1:0]     base_pos;
    logic [OW-1:0]     base_fill;
    logic [PW:0]       pos_inc;

    dq_cmd_t           min_cmd;
    dq_cmd_t           max_cmd;
    logic              min_idle;
    logic              max_idle;
    sample_t           min_head;
    sample_t           max_head;

    // The register interface never stalls; a write to window_length also restarts
    // the sequence, so the deques and counters are cleared with it.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_LENGTH)
        begin
            prdata = 32'(wlen_reg);
        end
    end

    // A window of zero behaves as one; anything beyond the store depth is clamped.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            win_eff = OW'(1);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            win_eff = OW'(MAX_WINDOW);
        end
        else
        begin
            win_eff = OW'(wlen_reg);
        end
    end

    // A transaction is in flight while st_reg is ST_BUSY. Once both deque engines are
    // back to idle, their head caches hold the window minimum and maximum. The next
    // input transaction is taken in that same cycle, as long as the output register
    // can take the pending result.
    assign units_idle = min_idle && max_idle;
    assign slot_free  = !out_valid_reg || result_ready;
    assign can_finish = (st_reg == ST_BUSY) && units_idle && (!emit_reg || slot_free);
    assign item_ready = (st_reg == ST_IDLE) || can_finish;
    assign item_acc   = item_valid && item_ready;

    // A start request restarts the position and fill counters at this sample.
    assign base_pos  = item.start_req ? '0 : pos_reg;
    assign base_fill = item.start_req ? '0 : fill_reg;
    assign pos_inc   = {1'b0, base_pos} + (PW+1)'(1);

    always_comb
    begin
        wlen_next      = wlen_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        st_next        = st_reg;
        emit_next      = emit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (result_valid && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    st_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (can_finish)
                begin
                    if (emit_reg)
                    begin
                        out_next.window_min = min_head;
                        out_next.window_max = ~max_head;
                        out_valid_next      = 1'b1;
                    end
                    st_next = item_acc ? ST_BUSY : ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        if (item_acc)
        begin
            if (pos_inc == (PW+1)'(2 * MAX_WINDOW))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc[PW-1:0];
            end
            if (base_fill < win_eff)
            begin
                fill_next = base_fill + OW'(1);
            end
            else
            begin
                fill_next = base_fill;
            end
            emit_next = ((base_fill < win_eff) ? (base_fill + OW'(1)) : base_fill) >= win_eff;
        end

        if (cfg_wr)
        begin
            wlen_next = pwdata[WLEN_W-1:0];
            pos_next  = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_W'(1);
            pos_reg       <= '0;
            fill_reg      <= '0;
            st_reg        <= ST_IDLE;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wlen_reg      <= wlen_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            st_reg        <= st_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Both engines run the minimum algorithm. The maximum engine sees inverted samples:
    // bitwise inversion reverses signed order, so its head, inverted back, is the maximum.
    always_comb
    begin
        min_cmd.go     = item_acc;
        min_cmd.clr    = cfg_wr;
        min_cmd.start  = item.start_req;
        min_cmd.sample = item.sample;
        max_cmd        = min_cmd;
        max_cmd.sample = ~item.sample;
    end

    swmm_deque #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_min_deque (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (min_cmd),
        .pos        (base_pos),
        .win        (win_eff),
        .idle       (min_idle),
        .head_value (min_head)
    );

    swmm_deque #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_max_deque (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (max_cmd),
        .pos        (base_pos),
        .win        (win_eff),
        .idle       (max_idle),
        .head_value (max_head)
    );

    // With no transaction in flight, neither deque engine may still be working.
    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_IDLE |-> min_idle && max_idle)
        else $error("deque engine busy with no transaction in flight");

    // The fill count never passes the effective window.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("fill count beyond window length");

    // A window_length write restarts the sequence counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (fill_reg == '0) && (pos_reg == '0))
        else $error("sequence not restarted after window_length write");

    // Both engines are started together and must both have finished before a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_BUSY) && !units_idle |=> !$rose(result_valid))
        else $error("result produced while a deque engine was busy");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the sliding window minimum/maximum block.
//
// Samples go in one transaction at a time. The testbench keeps its own pair of
// monotonic deques, updated at every accepted input transaction. Whenever a full
// window has been seen, it queues the minimum and maximum that the block must
// return. The monitor pops that queue for each accepted result and compares both
// fields. The window length is changed over the APB port only while the block is
// idle, and each write is read back.
module tb_top;

    import swmm_pkg::*;

    localparam int unsigned MAX_WINDOW = 1024;
    localparam int unsigned IDX_W      = $clog2(MAX_WINDOW);
    localparam int unsigned POS_W      = IDX_W + 1;

    // A result waits on the tail entries that its sample pops. A deque holds at most
    // a full window, so this bound covers the worst case.
    localparam int SETTLE_CYCLES = MAX_WINDOW + 8;
    localparam int STALL_LIMIT   = 20000;
    localparam int LONG_HOLD     = 400;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [2:0] WINDOW_LENGTH_ADDR = {REG_WINDOW_LENGTH, 2'b00};

    localparam int LANE_MIN = 0;
    localparam int LANE_MAX = 1;

    typedef enum int {
        STYLE_WIDE,
        STYLE_NARROW,
        STYLE_RAMP,
        STYLE_MIXED
    } sample_style_t;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    // Every input starts at a known value, with reset asserted from time zero.
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;

    sliding_window_min_max #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transactions waiting to be offered, and window extremes waiting to come back.
    item_t   pending_items[$];
    result_t window_extremes_q[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    // Shadow copy of the block: one deque per extreme, in ring storage.
    sample_t           lane_val [2][MAX_WINDOW];
    logic [POS_W-1:0]  lane_pos [2][MAX_WINDOW];
    logic [IDX_W-1:0]  lane_head [2];
    logic [POS_W-1:0]  lane_fill [2];
    logic [POS_W-1:0]  seq_pos;
    logic [POS_W-1:0]  seen_count;
    logic [WLEN_W-1:0] wl_setting;

    // State of the ramp generator, so that runs can span many transactions.
    sample_t ramp_val  = '0;
    int      ramp_left = 0;
    bit      ramp_up   = 1'b1;

    function automatic void restart_sequence();
        lane_head[LANE_MIN] = '0;
        lane_head[LANE_MAX] = '0;
        lane_fill[LANE_MIN] = '0;
        lane_fill[LANE_MAX] = '0;
        seq_pos             = '0;
        seen_count          = '0;
    endfunction

    // Drop an expired head entry, pop the tail entries that the new sample beats,
    // then append the sample. The min deque stays strictly increasing and the max
    // deque strictly decreasing, so ties pop the older entry.
    function automatic void lane_push(int lane, sample_t v, logic [POS_W-1:0] span);
        logic [IDX_W-1:0] slot;
        logic [POS_W-1:0] age;
        bit               beaten;
        if (lane_fill[lane] != 0)
        begin
            age = seq_pos - lane_pos[lane][lane_head[lane]];
            if (age >= span)
            begin
                lane_head[lane]++;
                lane_fill[lane]--;
            end
        end
        while (lane_fill[lane] != 0)
        begin
            slot   = lane_head[lane] + IDX_W'(lane_fill[lane] - 1'b1);
            beaten = (lane == LANE_MIN) ? (lane_val[lane][slot] >= v)
                                        : (lane_val[lane][slot] <= v);
            if (!beaten)
                break;
            lane_fill[lane]--;
        end
        if (lane_fill[lane] < MAX_WINDOW)
        begin
            slot                 = lane_head[lane] + IDX_W'(lane_fill[lane]);
            lane_val[lane][slot] = v;
            lane_pos[lane][slot] = seq_pos;
            lane_fill[lane]++;
        end
    endfunction

    // Work out what one accepted transaction must produce. A window length of zero
    // behaves as one, and anything above the deque depth behaves as the full depth.
    function automatic void predict_extremes(item_t it);
        logic [POS_W-1:0] span;
        result_t          r;
        if (wl_setting == 0)
            span = POS_W'(1);
        else if (wl_setting > MAX_WINDOW)
            span = POS_W'(MAX_WINDOW);
        else
            span = POS_W'(wl_setting);
        // A start request opens a new sequence, and this sample is its first.
        if (it.start_req)
            restart_sequence();
        lane_push(LANE_MIN, it.sample, span);
        lane_push(LANE_MAX, it.sample, span);
        seq_pos++;
        if (seen_count < span)
            seen_count++;
        if (seen_count >= span)
        begin
            r.window_min = lane_val[LANE_MIN][lane_head[LANE_MIN]];
            r.window_max = lane_val[LANE_MAX][lane_head[LANE_MAX]];
            window_extremes_q.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(string what, longint want_v, longint got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want_v, got_v);
    endfunction

    function automatic item_t next_item(sample_style_t style, int start_permille,
                                        int ramp_limit);
        item_t it;
        it.start_req = ($urandom_range(999) < start_permille);
        case (style)
            STYLE_WIDE:
                it.sample = $urandom;
            STYLE_NARROW:
                // Few distinct values, so ties and long pop chains are common.
                it.sample = sample_t'(int'($urandom_range(6)) - 3);
            STYLE_RAMP:
            begin
                // Monotonic runs grow one deque deep while emptying the other.
                if (ramp_left == 0)
                begin
                    ramp_left = $urandom_range(ramp_limit, 1);
                    ramp_up   = $urandom_range(1);
                    ramp_val  = $urandom;
                end
                ramp_left--;
                if (ramp_up)
                    ramp_val = ramp_val + $urandom_range(255);
                else
                    ramp_val = ramp_val - $urandom_range(255);
                it.sample = ramp_val;
            end
            default:
            begin
                case ($urandom_range(3))
                    0:       it.sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
                    1:       it.sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
                    2:       it.sample = sample_t'(int'($urandom_range(20)) - 10);
                    default: it.sample = $urandom;
                endcase
            end
        endcase
        return it;
    endfunction

    function automatic void push_item(sample_t v, logic start);
        item_t it;
        it.sample    = v;
        it.start_req = start;
        pending_items.push_back(it);
    endfunction

    // Sender: offers the next pending transaction unless it chooses to idle, and
    // holds valid and the payload steady until the block takes them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_extremes(item);
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker. Each accepted result is compared with the oldest
    // expectation. A long hold-off can be requested, during which ready stays low
    // so that the block backs up and stops taking samples.
    always @(posedge clk)
    begin : result_side
        result_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (window_extremes_q.size() == 0)
                    report_mismatch("result with nothing expected, window_min", 0,
                                    longint'(result.window_min));
                else
                begin
                    want = window_extremes_q.pop_front();
                    if (result.window_min !== want.window_min)
                        report_mismatch("window_min", longint'(want.window_min),
                                        longint'(result.window_min));
                    if (result.window_max !== want.window_max)
                        report_mismatch("window_max", longint'(want.window_max),
                                        longint'(result.window_max));
                end
            end
            if (psel && penable && !pwrite && pready && prdata !== 32'(wl_setting))
                report_mismatch("window_length readback", longint'(wl_setting),
                                longint'(prdata));
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run when nothing has moved on any port for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // Checked on falling edges, when everything driven at the rising edge is stable.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || item_valid || window_extremes_q.size() != 0);
    endtask

    // Samples that complete no window leave nothing to wait for, so give the block
    // time to finish its last pop chain.
    task automatic settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(bit is_write, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= WINDOW_LENGTH_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A window length write also restarts the sequence, in the block and here.
    task automatic set_window(logic [31:0] value);
        settle();
        apb_access(1'b1, value);
        wl_setting = value[WLEN_W-1:0];
        restart_sequence();
        apb_access(1'b0, '0);
    endtask

    task automatic run_phase(sample_style_t style, int n_items, int start_permille,
                             pace_t pace, int ramp_limit, bit long_hold);
        @(negedge clk);
        send_idle_pct  = (pace == PACE_SENDER_IDLE)    ? 69 :
                         (pace == PACE_BOTH)           ? 19 : 0;
        recv_stall_pct = (pace == PACE_RECEIVER_STALL) ? 69 :
                         (pace == PACE_BOTH)           ? 19 : 0;
        if (long_hold)
            hold_req = 1'b1;
        // The first ramp of a phase runs at full length, so a large window can
        // fill one deque completely.
        ramp_left = ramp_limit;
        ramp_up   = 1'b1;
        ramp_val  = $urandom;
        for (int k = 0; k < n_items; k++)
            pending_items.push_back(next_item(style, start_permille, ramp_limit));
        wait_drained();
    endtask

    initial
    begin
        wl_setting = WLEN_W'(1);
        restart_sequence();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The reset window of one returns every sample as both
        // extremes, including the most negative and most positive values.
        @(negedge clk);
        push_item({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1);
        push_item({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
        push_item(0, 1'b1);
        push_item(-1, 1'b0);
        push_item(32'h5555_5555, 1'b0);
        push_item(32'hAAAA_AAAA, 1'b1);
        wait_drained();

        // A window length of zero acts as one.
        set_window(32'd0);
        @(negedge clk);
        push_item(42, 1'b0);
        push_item(-42, 1'b1);
        wait_drained();

        // Window of three, written with junk in the unused upper bits. Equal
        // samples exercise the tie rule, and a start request in the middle means
        // no result until three samples of the new sequence are in.
        set_window(32'hFFFF_F803);
        @(negedge clk);
        push_item(5, 1'b0);
        push_item(5, 1'b0);
        push_item(5, 1'b0);
        push_item(7, 1'b0);
        push_item(-2, 1'b0);
        push_item(9, 1'b1);
        push_item(1, 1'b0);
        push_item(2, 1'b0);
        push_item(4, 1'b0);
        wait_drained();

        // Alternating extremes with a window of two.
        set_window(32'd2);
        @(negedge clk);
        push_item({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
        push_item({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
        push_item({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
        push_item({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
        wait_drained();

        // Random part, cycling through the pacing modes.
        set_window(32'd4);
        run_phase(STYLE_WIDE, 120, 15, PACE_FREE, 1, 1'b0);
        set_window(32'd7);
        run_phase(STYLE_NARROW, 120, 15, PACE_SENDER_IDLE, 1, 1'b0);
        set_window(32'd16);
        run_phase(STYLE_RAMP, 120, 10, PACE_RECEIVER_STALL, 40, 1'b0);

        // The receiver holds off for a long stretch while the sender keeps going.
        set_window(32'd5);
        run_phase(STYLE_MIXED, 200, 10, PACE_FREE, 1, 1'b1);
        // The sender has paused until everything came back; the sequence continues.
        run_phase(STYLE_WIDE, 80, 0, PACE_BOTH, 1, 1'b0);

        // Long window. Ramps longer than the window fill one deque to the window
        // length, so expired heads are dropped while long pop chains run.
        set_window(32'd300);
        run_phase(STYLE_RAMP, 390, 0, PACE_BOTH, 350, 1'b0);
        // Short window, frequent restarts.
        set_window(32'd2);
        run_phase(STYLE_MIXED, 100, 50, PACE_RECEIVER_STALL, 1, 1'b0);

        wait_drained();
        settle();
        if (mismatch_count == 0 && window_extremes_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
